@@ hw/rtl/grr_pkg.sv @@
// Shared constants, codes and interface types of the glyph row rasteriser.
`default_nettype none

package grr_pkg;

    // Defaults for the top-level parameters.
    localparam int FONT_CHARS_DEF = 256;
    localparam int TALL_ROWS_DEF  = 16;

    // Fixed geometry of the short font and of the field widths.
    localparam int SHORT_ROWS   = 8;
    localparam int ADDR_W       = 24;
    localparam int STRIDE_W     = 13;
    localparam int POS_X_W      = 12;
    localparam int POS_Y_W      = 11;
    localparam int CODE_W       = 8;
    localparam int ROW_W        = 4;
    localparam int COLOUR_W     = 4;
    localparam int PAL_DEPTH    = 256;
    localparam int PIX_W        = 64;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd640;
    localparam logic [7:0]          COLOUR_MASK  = 8'h0f;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_DRAW    = 2'd0,
        KIND_FONT    = 2'd1,
        KIND_PALETTE = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // Font row write request.
    typedef struct packed {
        logic              en;
        logic              tall;
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [7:0]        data;
    } t_font_wr;

    // Font row read request.
    typedef struct packed {
        logic              en;
        logic              tall;
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
    } t_font_rd;

    // Palette write request.
    typedef struct packed {
        logic       en;
        logic [7:0] index;
        logic [7:0] data;
    } t_pal_wr;

    // Palette read request for both colours of a draw.
    typedef struct packed {
        logic       en;
        logic [7:0] fore;
        logic [7:0] back;
    } t_pal_rd;

endpackage : grr_pkg

`default_nettype wire

@@ hw/rtl/grr_font_store.sv @@
// Tall and short font memories with one write port and one registered read port.
`default_nettype none

module grr_font_store
    import grr_pkg::*;
#(
    parameter int FONT_CHARS = FONT_CHARS_DEF,
    parameter int TALL_ROWS  = TALL_ROWS_DEF
) (
    input  wire logic     i_clk,
    input  wire t_font_wr i_wr,
    input  wire t_font_rd i_rd,
    output logic [7:0]    o_bits
);

    localparam int TALL_DEPTH  = FONT_CHARS * TALL_ROWS;
    localparam int SHORT_DEPTH = FONT_CHARS * SHORT_ROWS;
    localparam int TALL_IW     = $clog2(TALL_DEPTH);
    localparam int SHORT_IW    = $clog2(SHORT_DEPTH);
    localparam int SUM_W       = 13;

    logic [7:0] tall_mem  [TALL_DEPTH];
    logic [7:0] short_mem [SHORT_DEPTH];

    logic [SUM_W-1:0]    wr_tall_sum, wr_short_sum, rd_tall_sum, rd_short_sum;
    logic [TALL_IW-1:0]  wr_tall_idx, rd_tall_idx;
    logic [SHORT_IW-1:0] wr_short_idx, rd_short_idx;
    logic                wr_code_ok, rd_code_ok;
    logic                wr_tall_ok, wr_short_ok;

    logic [7:0] r_tall_q, r_short_q;
    logic       r_sel_tall, r_code_ok;

    // Linear entry positions: character times rows per glyph plus row.
    always_comb begin
        wr_tall_sum  = SUM_W'(i_wr.code) * SUM_W'(TALL_ROWS) + SUM_W'(i_wr.row);
        wr_short_sum = SUM_W'(i_wr.code) * SUM_W'(SHORT_ROWS) + SUM_W'(i_wr.row);
        rd_tall_sum  = SUM_W'(i_rd.code) * SUM_W'(TALL_ROWS) + SUM_W'(i_rd.row);
        rd_short_sum = SUM_W'(i_rd.code) * SUM_W'(SHORT_ROWS) + SUM_W'(i_rd.row);
        wr_tall_idx  = wr_tall_sum[TALL_IW-1:0];
        wr_short_idx = wr_short_sum[SHORT_IW-1:0];
        rd_tall_idx  = rd_tall_sum[TALL_IW-1:0];
        rd_short_idx = rd_short_sum[SHORT_IW-1:0];
        wr_code_ok   = 9'(i_wr.code) < 9'(FONT_CHARS);
        rd_code_ok   = 9'(i_rd.code) < 9'(FONT_CHARS);
        wr_tall_ok   = 5'(i_wr.row) < 5'(TALL_ROWS);
        wr_short_ok  = 5'(i_wr.row) < 5'(SHORT_ROWS);
    end

    // Writes that name a missing character or row are dropped.
    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_code_ok && i_wr.tall && wr_tall_ok) begin
            tall_mem[wr_tall_idx] <= i_wr.data;
        end
        if (i_wr.en && wr_code_ok && !i_wr.tall && wr_short_ok) begin
            short_mem[wr_short_idx] <= i_wr.data;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_tall_q   <= tall_mem[rd_tall_idx];
            r_short_q  <= short_mem[rd_short_idx];
            r_sel_tall <= i_rd.tall;
            r_code_ok  <= rd_code_ok;
        end
    end

    // A character beyond the font reads as an empty row.
    assign o_bits = !r_code_ok ? 8'h00 : (r_sel_tall ? r_tall_q : r_short_q);

endmodule : grr_font_store

`default_nettype wire

@@ hw/rtl/grr_palette.sv @@
// Colour table memory with one write port and two registered read ports.
`default_nettype none

module grr_palette
    import grr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_pal_wr     i_wr,
    input  wire t_pal_rd     i_rd,
    output logic [COLOUR_W-1:0] o_fore,
    output logic [COLOUR_W-1:0] o_back
);

    logic [7:0] pal_mem [PAL_DEPTH];
    logic [7:0] r_fore_q, r_back_q;

    // Entry writes.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            pal_mem[i_wr.index] <= i_wr.data;
        end
    end

    // Both colours of a draw are read together and held for the whole glyph.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_fore_q <= pal_mem[i_rd.fore];
            r_back_q <= pal_mem[i_rd.back];
        end
    end

    // Only the low four bits of an entry are a colour.
    always_comb begin
        logic [7:0] fore_m;
        logic [7:0] back_m;
        fore_m = r_fore_q & COLOUR_MASK;
        back_m = r_back_q & COLOUR_MASK;
        o_fore = fore_m[COLOUR_W-1:0];
        o_back = back_m[COLOUR_W-1:0];
    end

endmodule : grr_palette

`default_nettype wire

@@ hw/rtl/glyph_row_rasterizer.sv @@
// A draw's first row passes the prepare state, the read stage and the output register.
// Throughput: one pixel row per cycle unless the output stalls, set by the single font
// read port. A draw holds the input until its last row leaves the read stage.
// Reset: synchronous, active low; clears control state and sets the stride to 640.
// Font and colour memories are not cleared and are undefined until written.
`default_nettype none

module glyph_row_rasterizer
    import grr_pkg::*;
#(
    parameter int FONT_CHARS = FONT_CHARS_DEF,
    parameter int TALL_ROWS  = TALL_ROWS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input items
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_kind,
    input  wire logic [POS_X_W-1:0]  i_pos_x,
    input  wire logic [POS_Y_W-1:0]  i_pos_y,
    input  wire logic [CODE_W-1:0]   i_char_code,
    input  wire logic [7:0]          i_fore_index,
    input  wire logic [7:0]          i_back_index,
    input  wire logic                i_tall_font,
    input  wire logic                i_see_through,
    input  wire logic [ROW_W-1:0]    i_glyph_row,
    input  wire logic [7:0]          i_load_data,
    // Result items
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [ADDR_W-1:0]        o_pixel_address,
    output logic [PIX_W-1:0]         o_pixel_bytes,
    output logic [7:0]               o_write_mask,
    output logic                     o_last_row,
    // Configuration
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [STRIDE_W-1:0] i_cfg_line_stride
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PREP = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    t_state r_state;

    logic [STRIDE_W-1:0] r_stride;
    logic [ADDR_W-1:0]   r_addr;
    logic [POS_X_W-1:0]  r_x;
    logic [CODE_W-1:0]   r_code;
    logic                r_tall, r_see;
    logic [ROW_W-1:0]    r_row;

    logic                r_b_valid, r_b_last;
    logic [ADDR_W-1:0]   r_b_addr;

    logic                r_o_valid, r_o_last;
    logic [ADDR_W-1:0]   r_o_addr;
    logic [PIX_W-1:0]    r_o_pix;
    logic [7:0]          r_o_mask;

    logic                in_acc, draw_acc, adv, issue, issue_last;
    logic [ROW_W-1:0]    rows_last;
    logic [7:0]          font_bits;
    logic [COLOUR_W-1:0] fore_c, back_c;
    logic [PIX_W-1:0]    row_pix;
    logic [7:0]          row_mask;

    t_font_wr font_wr;
    t_font_rd font_rd;
    t_pal_wr  pal_wr;
    t_pal_rd  pal_rd;

    // Handshakes and pipeline advance.
    assign o_in_ready = (r_state == S_IDLE) && !r_b_valid;
    assign o_cfg_ready = 1'b1;
    assign in_acc     = i_in_valid && o_in_ready;
    assign draw_acc   = in_acc && (t_kind'(i_kind) == KIND_DRAW);
    assign adv        = !r_o_valid || i_out_ready;
    assign issue      = (r_state == S_RUN) && (adv || !r_b_valid);
    assign rows_last  = r_tall ? ROW_W'(TALL_ROWS - 1) : ROW_W'(SHORT_ROWS - 1);
    assign issue_last = r_row == rows_last;

    // Memory requests.
    always_comb begin
        font_wr.en   = in_acc && (t_kind'(i_kind) == KIND_FONT);
        font_wr.tall = i_tall_font;
        font_wr.code = i_char_code;
        font_wr.row  = i_glyph_row;
        font_wr.data = i_load_data;
        font_rd.en   = issue;
        font_rd.tall = r_tall;
        font_rd.code = r_code;
        font_rd.row  = r_row;
        pal_wr.en    = in_acc && (t_kind'(i_kind) == KIND_PALETTE);
        pal_wr.index = i_char_code;
        pal_wr.data  = i_load_data;
        pal_rd.en    = draw_acc;
        pal_rd.fore  = i_fore_index;
        pal_rd.back  = i_back_index;
    end

    grr_font_store #(
        .FONT_CHARS (FONT_CHARS),
        .TALL_ROWS  (TALL_ROWS)
    ) u_font (
        .i_clk  (i_clk),
        .i_wr   (font_wr),
        .i_rd   (font_rd),
        .o_bits (font_bits)
    );

    grr_palette u_pal (
        .i_clk  (i_clk),
        .i_wr   (pal_wr),
        .i_rd   (pal_rd),
        .o_fore (fore_c),
        .o_back (back_c)
    );

    // Line stride register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stride <= i_cfg_line_stride;
        end
    end

    // Row sequencer: the product y * stride is taken at acceptance, x is added in the
    // prepare state, then one font row is read per cycle while the output is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (draw_acc) begin
                        r_state <= S_PREP;
                        r_row   <= '0;
                    end
                end
                S_PREP: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (issue) begin
                        r_row <= r_row + 1'b1;
                        if (issue_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Draw context and running row address.
    always_ff @(posedge i_clk) begin
        if (draw_acc) begin
            r_addr <= ADDR_W'(i_pos_y * r_stride);
            r_x    <= i_pos_x;
            r_code <= i_char_code;
            r_tall <= i_tall_font;
            r_see  <= i_see_through;
        end else if (r_state == S_PREP) begin
            r_addr <= r_addr + ADDR_W'(r_x);
        end else if (issue) begin
            r_addr <= r_addr + ADDR_W'(r_stride);
        end
    end

    // Read stage: follows the font memory's read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (issue) begin
            r_b_valid <= 1'b1;
        end else if (adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_addr <= r_addr;
            r_b_last <= issue_last;
        end
    end

    // Pixel expansion: the font's most significant bit becomes byte 0.
    always_comb begin
        logic on;
        row_pix  = '0;
        row_mask = '0;
        for (int k = 0; k < 8; k++) begin
            on = font_bits[7 - k];
            if (on) begin
                row_pix[8*k +: 8] = 8'(fore_c);
            end else if (!r_see) begin
                row_pix[8*k +: 8] = 8'(back_c);
            end
            row_mask[k] = on;
        end
        if (!r_see) begin
            row_mask = 8'hff;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_b_valid) begin
            r_o_addr <= r_b_addr;
            r_o_pix  <= row_pix;
            r_o_mask <= row_mask;
            r_o_last <= r_b_last;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_pixel_address = r_o_addr;
    assign o_pixel_bytes   = r_o_pix;
    assign o_write_mask    = r_o_mask;
    assign o_last_row      = r_o_last;

    // A draw always passes through the prepare cycle.
    a_draw_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draw_acc |=> (r_state == S_PREP))
        else $error("draw accepted without entering prepare");

    // Font reads are issued only while a glyph is running.
    a_issue_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_b_valid) |-> $past(r_state == S_RUN))
        else $error("read stage filled outside the run state");

    // Once the last row has been read the sequencer has stopped.
    a_last_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_last) |-> (r_state != S_RUN))
        else $error("sequencer still running after the last row");

    // The input is never taken while a row waits in the read stage.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> !o_in_ready)
        else $error("input ready while a row is in flight");

endmodule : glyph_row_rasterizer

`default_nettype wire
